FILE: hw/rtl/imsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imsc_pkg
// Shared types and constants of the infrared mark/space capture qualifier.
// ----------------------------------------------------------------------------
package imsc_pkg;

   localparam int DurWidth   = 15;
   localparam int CountWidth = 8;
   localparam int SumWidth   = 23;
   localparam int TotalWidth = 22;

   // register indexes on the configuration port
   localparam logic [1:0] REG_MIN_LENGTH     = 2'd0;
   localparam logic [1:0] REG_MIN_TOTAL_TIME = 2'd1;
   localparam logic [1:0] REG_BURST_LEVEL    = 2'd2;

   localparam logic [CountWidth-1:0] MIN_LENGTH_RESET     = 8'd4;
   localparam logic [TotalWidth-1:0] MIN_TOTAL_TIME_RESET = 22'd2000;
   localparam logic                  BURST_LEVEL_RESET    = 1'b0;

   // result kinds
   localparam logic KIND_KEPT    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // verdict codes
   localparam logic [1:0] VERDICT_ACCEPTED  = 2'd0;
   localparam logic [1:0] VERDICT_EMPTY     = 2'd1;
   localparam logic [1:0] VERDICT_TOO_SHORT = 2'd2;

   localparam int QueueDepth    = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);

   typedef struct packed {
      logic [CountWidth-1:0] min_length;
      logic [TotalWidth-1:0] min_total_time;
      logic                  burst_level;
   } cfg_type;

   // one classified item on its way to the output side
   typedef struct packed {
      logic                  has_kept;
      logic                  has_verdict;
      logic [DurWidth-1:0]   duration;
      logic [1:0]            verdict;
      logic [CountWidth-1:0] count;
      logic [TotalWidth-1:0] total;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: hw/rtl/ir_mark_space_capture_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_mark_space_capture_qualifier
// Qualifies received infrared edges into alternating mark/space durations
// and gives a verdict at the end of each capture frame.
// ----------------------------------------------------------------------------
// The block takes one edge per clock cycle while req_stall is low, which it
// is whenever the four-entry queue has room. An accepted edge is classified
// in the cycle it is accepted and passes through the queue into the result
// register. The last edge of a frame that is also kept gives a kept duration
// and then the verdict; any other edge that is kept or ends a frame gives one
// result. Dropped edges that are not a frame end give no result and cost
// nothing at the output. The user must write registers through the APB port
// only while the block is idle; the block itself does not enforce this.
module ir_mark_space_capture_qualifier import imsc_pkg::*; #(
   parameter int MAX_KEPT = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_edge_level,
   input  logic [DurWidth-1:0]   req_edge_duration,
   input  logic                  req_frame_end,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_result_kind,
   output logic [DurWidth-1:0]   rsp_kept_duration,
   output logic [1:0]            rsp_verdict,
   output logic [CountWidth-1:0] rsp_kept_count,
   output logic [TotalWidth-1:0] rsp_total_time,
   output logic                  rsp_run_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [3:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   cfg_type          cfg_ff;
   queue_status_type q_status;
   logic             push;
   logic             pop;
   entry_type        push_entry;
   entry_type        pop_entry;
   logic             cfg_write;
   logic [1:0]       reg_index;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign reg_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_length     <= MIN_LENGTH_RESET;
         cfg_ff.min_total_time <= MIN_TOTAL_TIME_RESET;
         cfg_ff.burst_level    <= BURST_LEVEL_RESET;
      end else if (cfg_write) begin
         case (reg_index)
            REG_MIN_LENGTH: begin
               cfg_ff.min_length <= pwdata[CountWidth-1:0];
            end
            REG_MIN_TOTAL_TIME: begin
               cfg_ff.min_total_time <= pwdata[TotalWidth-1:0];
            end
            REG_BURST_LEVEL: begin
               cfg_ff.burst_level <= pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_MIN_LENGTH:     prdata = 32'(cfg_ff.min_length);
         REG_MIN_TOTAL_TIME: prdata = 32'(cfg_ff.min_total_time);
         REG_BURST_LEVEL:    prdata = 32'(cfg_ff.burst_level);
         default:            prdata = '0;
      endcase
   end

   imsc_front #(
      .MAX_KEPT (MAX_KEPT)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_edge_level    (req_edge_level),
      .req_edge_duration (req_edge_duration),
      .req_frame_end     (req_frame_end),
      .cfg               (cfg_ff),
      .q_status          (q_status),
      .push              (push),
      .push_entry        (push_entry)
   );

   imsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   imsc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .pop_entry         (pop_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_kept_duration (rsp_kept_duration),
      .rsp_verdict       (rsp_verdict),
      .rsp_kept_count    (rsp_kept_count),
      .rsp_total_time    (rsp_total_time),
      .rsp_run_last      (rsp_run_last)
   );

`ifndef SYNTHESIS
   // a kept duration is never zero and carries no verdict
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_KEPT) |->
         (rsp_kept_duration != '0 && rsp_verdict == VERDICT_ACCEPTED &&
          rsp_kept_count != '0))
      else $error("kept result with bad fields");

   // a verdict always closes the run of results of its item
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_VERDICT) |->
         (rsp_run_last && rsp_kept_duration == '0 && rsp_verdict != 2'd3))
      else $error("verdict result with bad fields");

   // empty verdict only for a frame without kept durations
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_VERDICT) |->
         ((rsp_verdict == VERDICT_EMPTY) == (rsp_kept_count == '0)))
      else $error("empty verdict does not match kept count");

   // a kept duration not marked last is followed by its verdict
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_result_kind == KIND_KEPT && !rsp_run_last) |=>
         (rsp_valid && rsp_result_kind == KIND_VERDICT))
      else $error("verdict missing after kept duration");
`endif

endmodule

FILE: hw/rtl/imsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imsc_front
// Accepts edges, applies the mark/space alternation rules, keeps the frame
// count and total, and queues one entry per item that gives a result.
// ----------------------------------------------------------------------------
module imsc_front import imsc_pkg::*; #(
   parameter int MAX_KEPT = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_edge_level,
   input  logic [DurWidth-1:0]   req_edge_duration,
   input  logic                  req_frame_end,
   input  cfg_type               cfg,
   input  queue_status_type      q_status,
   output logic                  push,
   output entry_type             push_entry
);

   logic                  started_ff, started_in;
   logic                  expect_ff, expect_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [SumWidth-1:0]   sum_ff, sum_in;

   logic                  accept;
   logic                  is_mark;
   logic                  room;
   logic                  keep;
   logic [CountWidth-1:0] count_new;
   logic [SumWidth-1:0]   sum_new;
   logic [1:0]            verdict;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign is_mark   = (req_edge_level == cfg.burst_level);
   assign room      = (req_edge_duration != '0) && (count_ff < CountWidth'(MAX_KEPT));
   // before the first mark only a mark is kept
   assign keep      = room && (started_ff ? (expect_ff == is_mark) : is_mark);
   assign count_new = count_ff + CountWidth'(keep);
   assign sum_new   = sum_ff + (keep ? SumWidth'(req_edge_duration) : '0);

   always_comb begin
      if (count_new == '0) begin
         verdict = VERDICT_EMPTY;
      end else if ((count_new < cfg.min_length) ||
                   (sum_new < SumWidth'(cfg.min_total_time))) begin
         verdict = VERDICT_TOO_SHORT;
      end else begin
         verdict = VERDICT_ACCEPTED;
      end
   end

   always_comb begin
      started_in = started_ff;
      expect_in  = expect_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      if (accept) begin
         if (req_frame_end) begin
            started_in = 1'b0;
            expect_in  = 1'b1;
            count_in   = '0;
            sum_in     = '0;
         end else if (keep) begin
            started_in = 1'b1;
            expect_in  = !is_mark;
            count_in   = count_new;
            sum_in     = sum_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         expect_ff  <= 1'b1;
         count_ff   <= '0;
         sum_ff     <= '0;
      end else begin
         started_ff <= started_in;
         expect_ff  <= expect_in;
         count_ff   <= count_in;
         sum_ff     <= sum_in;
      end
   end

   assign push = accept && (keep || req_frame_end);

   always_comb begin
      push_entry.has_kept    = keep;
      push_entry.has_verdict = req_frame_end;
      push_entry.duration    = req_edge_duration;
      push_entry.verdict     = verdict;
      push_entry.count       = count_new;
      // reported total saturates, the verdict uses the full sum
      push_entry.total       = sum_new[SumWidth-1] ? '1 : sum_new[TotalWidth-1:0];
   end

endmodule

FILE: hw/rtl/imsc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imsc_queue
// Short first-in first-out queue of classified entries between the front
// and the back.
// ----------------------------------------------------------------------------
module imsc_queue import imsc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        pop_entry,
   output queue_status_type status
);

   entry_type                mem_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrWidth:0]   fill_ff, fill_in;

   assign status.full  = (fill_ff == (QueuePtrWidth+1)'(QueueDepth));
   assign status.empty = (fill_ff == '0);
   assign pop_entry    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QueuePtrWidth'(push);
      rd_ptr_in = rd_ptr_ff + QueuePtrWidth'(pop);
      fill_in   = fill_ff + (QueuePtrWidth+1)'(push) - (QueuePtrWidth+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: hw/rtl/imsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imsc_back
// Takes queued entries and sends their results through the output
// register, a kept duration first and then the verdict where both exist.
// ----------------------------------------------------------------------------
module imsc_back import imsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  queue_status_type      q_status,
   input  entry_type             pop_entry,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_result_kind,
   output logic [DurWidth-1:0]   rsp_kept_duration,
   output logic [1:0]            rsp_verdict,
   output logic [CountWidth-1:0] rsp_kept_count,
   output logic [TotalWidth-1:0] rsp_total_time,
   output logic                  rsp_run_last
);

   logic                  valid_ff, valid_in;
   logic                  pend_ff, pend_in;
   logic [1:0]            pend_verdict_ff;
   logic                  kind_ff;
   logic [DurWidth-1:0]   dur_ff;
   logic [1:0]            verdict_ff;
   logic [CountWidth-1:0] count_ff;
   logic [TotalWidth-1:0] total_ff;
   logic                  last_ff;

   logic out_free;

   assign out_free = !valid_ff || !rsp_stall;
   assign pop      = out_free && !pend_ff && !q_status.empty;

   always_comb begin
      valid_in = valid_ff;
      pend_in  = pend_ff;
      if (out_free) begin
         if (pend_ff) begin
            valid_in = 1'b1;
            pend_in  = 1'b0;
         end else if (!q_status.empty) begin
            valid_in = 1'b1;
            pend_in  = pop_entry.has_kept && pop_entry.has_verdict;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (pend_ff) begin
            // count and total stay as sent with the kept duration
            kind_ff    <= KIND_VERDICT;
            dur_ff     <= '0;
            verdict_ff <= pend_verdict_ff;
            last_ff    <= 1'b1;
         end else if (!q_status.empty) begin
            kind_ff         <= pop_entry.has_kept ? KIND_KEPT : KIND_VERDICT;
            dur_ff          <= pop_entry.has_kept ? pop_entry.duration : '0;
            verdict_ff      <= pop_entry.has_kept ? VERDICT_ACCEPTED : pop_entry.verdict;
            count_ff        <= pop_entry.count;
            total_ff        <= pop_entry.total;
            last_ff         <= !(pop_entry.has_kept && pop_entry.has_verdict);
            pend_verdict_ff <= pop_entry.verdict;
         end
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_kept_duration = dur_ff;
   assign rsp_verdict       = verdict_ff;
   assign rsp_kept_count    = count_ff;
   assign rsp_total_time    = total_ff;
   assign rsp_run_last      = last_ff;

endmodule

FILE: bench/ir_capture_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_capture_checker
// Watches the edge, result and register ports of the capture qualifier,
// predicts the kept durations and frame verdicts of every accepted edge and
// compares each accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module ir_capture_checker import imsc_pkg::*; #(
   parameter int MaxKept = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_edge_level,
   input  logic [DurWidth-1:0]   req_edge_duration,
   input  logic                  req_frame_end,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_result_kind,
   input  logic [DurWidth-1:0]   rsp_kept_duration,
   input  logic [1:0]            rsp_verdict,
   input  logic [CountWidth-1:0] rsp_kept_count,
   input  logic [TotalWidth-1:0] rsp_total_time,
   input  logic                  rsp_run_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [3:0]            paddr,
   input  logic [31:0]           pwdata,
   output int                    error_count,
   output int                    pending,
   output int                    results_checked
);

   typedef struct packed {
      logic                  kind;
      logic [DurWidth-1:0]   duration;
      logic [1:0]            verdict;
      logic [CountWidth-1:0] count;
      logic [TotalWidth-1:0] total;
      logic                  last;
   } capture_result_type;

   capture_result_type expected_results[$];

   cfg_type               cfg;
   logic                  frame_open;
   logic                  want_mark;
   logic [CountWidth-1:0] kept_cnt;
   logic [SumWidth-1:0]   time_acc;
   int                    errors = 0;
   int                    checked = 0;

   function automatic logic [TotalWidth-1:0] clip_total(input logic [SumWidth-1:0] s);
      return (s > {1'b0, {TotalWidth{1'b1}}}) ? {TotalWidth{1'b1}} : s[TotalWidth-1:0];
   endfunction

   task automatic qualify_edge(input logic level, input logic [DurWidth-1:0] dur,
                               input logic last_edge);
      logic               is_mark;
      logic               keep;
      capture_result_type r;
      if (dur != 0 && kept_cnt < MaxKept) begin
         is_mark = (level == cfg.burst_level);
         keep = 1'b1;
         // nothing is kept before the first mark of a frame
         if (!frame_open) begin
            if (is_mark) begin
               frame_open = 1'b1;
               want_mark = 1'b1;
            end else begin
               keep = 1'b0;
            end
         end
         if (keep && want_mark == is_mark) begin
            kept_cnt = kept_cnt + 1'b1;
            time_acc = time_acc + SumWidth'(dur);
            want_mark = !want_mark;
            r.kind = KIND_KEPT;
            r.duration = dur;
            r.verdict = VERDICT_ACCEPTED;
            r.count = kept_cnt;
            r.total = clip_total(time_acc);
            r.last = !last_edge;
            expected_results.push_back(r);
         end
      end
      if (last_edge) begin
         r.kind = KIND_VERDICT;
         r.duration = '0;
         if (kept_cnt == 0)
            r.verdict = VERDICT_EMPTY;
         else if (kept_cnt < cfg.min_length || time_acc < SumWidth'(cfg.min_total_time))
            r.verdict = VERDICT_TOO_SHORT;
         else
            r.verdict = VERDICT_ACCEPTED;
         r.count = kept_cnt;
         r.total = clip_total(time_acc);
         r.last = 1'b1;
         expected_results.push_back(r);
         frame_open = 1'b0;
         want_mark = 1'b1;
         kept_cnt = '0;
         time_acc = '0;
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   task automatic compare_result();
      capture_result_type e;
      if (expected_results.size() == 0) begin
         errors++;
         $display("%0t: result with nothing expected, kind %0d duration %0d verdict %0d",
                  $time, rsp_result_kind, rsp_kept_duration, rsp_verdict);
      end else begin
         e = expected_results.pop_front();
         check_field("result_kind", e.kind, rsp_result_kind);
         check_field("kept_duration", e.duration, rsp_kept_duration);
         check_field("verdict", e.verdict, rsp_verdict);
         check_field("kept_count", e.count, rsp_kept_count);
         check_field("total_time", e.total, rsp_total_time);
         check_field("run_last", e.last, rsp_run_last);
         checked++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.min_length = MIN_LENGTH_RESET;
         cfg.min_total_time = MIN_TOTAL_TIME_RESET;
         cfg.burst_level = BURST_LEVEL_RESET;
         expected_results.delete();
         frame_open = 1'b0;
         want_mark = 1'b1;
         kept_cnt = '0;
         time_acc = '0;
      end else begin
         if (rsp_valid && !rsp_stall)
            compare_result();
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_MIN_LENGTH:     cfg.min_length = pwdata[CountWidth-1:0];
               REG_MIN_TOTAL_TIME: cfg.min_total_time = pwdata[TotalWidth-1:0];
               REG_BURST_LEVEL:    cfg.burst_level = pwdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            qualify_edge(req_edge_level, req_edge_duration, req_frame_end);
      end
      error_count <= errors;
      pending <= expected_results.size();
      results_checked <= checked;
   end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives infrared edge frames and register settings into the capture
// qualifier with random gaps and result stalls, and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top import imsc_pkg::*; ();

   localparam int         MaxKept     = 128;
   localparam int         DrainCycles = 8;
   localparam logic [1:0] RegUnused   = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_edge_level = 1'b0;
   logic [DurWidth-1:0]   req_edge_duration = '0;
   logic                  req_frame_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_result_kind;
   logic [DurWidth-1:0]   rsp_kept_duration;
   logic [1:0]            rsp_verdict;
   logic [CountWidth-1:0] rsp_kept_count;
   logic [TotalWidth-1:0] rsp_total_time;
   logic                  rsp_run_last;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [3:0]            paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   int   check_errors;
   int   check_pending;
   int   check_count;
   int   edges_sent = 0;
   int   frames_sent = 0;
   int   settings_used = 1;
   logic cur_mark = BURST_LEVEL_RESET;
   logic quiet = 1'b0;

   always #5 clock = ~clock;

   ir_mark_space_capture_qualifier #(.MAX_KEPT(MaxKept)) dut (.*);

   ir_capture_checker #(.MaxKept(MaxKept)) u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_edge_level, .req_edge_duration,
      .req_frame_end, .rsp_valid, .rsp_stall, .rsp_result_kind, .rsp_kept_duration,
      .rsp_verdict, .rsp_kept_count, .rsp_total_time, .rsp_run_last,
      .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
      .error_count(check_errors), .pending(check_pending), .results_checked(check_count)
   );

   // result side back-pressure: free runs, short stalls and the odd long one
   always @(posedge clock) begin
      int hold;
      int r;
      if (hold > 0) begin
         hold--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            rsp_stall <= 1'b0;
            hold = $urandom_range(0, 8);
         end else if (r < 85) begin
            rsp_stall <= 1'b1;
            hold = $urandom_range(0, 2);
         end else if (r < 95) begin
            rsp_stall <= 1'b1;
            hold = $urandom_range(5, 30);
         end else begin
            rsp_stall <= 1'b0;
            hold = $urandom_range(20, 80);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 65)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic logic [DurWidth-1:0] pick_duration();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)
         return DurWidth'(1);
      else if (r < 10)
         return {DurWidth{1'b1}};
      else if (r < 20)
         return DurWidth'($urandom_range(1, 32767));
      else if (r < 25)
         return '0;
      else
         return DurWidth'($urandom_range(150, 2500));
   endfunction

   task automatic send_edge(input logic lvl, input logic [DurWidth-1:0] dur,
                            input logic last_edge);
      int gap;
      req_valid <= 1'b1;
      req_edge_level <= lvl;
      req_edge_duration <= dur;
      req_frame_end <= last_edge;
      do @(posedge clock); while (req_stall);
      edges_sent++;
      if (last_edge)
         frames_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending and let every outstanding result come out
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (check_pending != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // upper data bits carry noise, the block keeps only the register width
   task automatic set_config(input logic [CountWidth-1:0] min_len,
                             input logic [TotalWidth-1:0] min_time, input logic mark);
      apb_write({REG_MIN_LENGTH, 2'b00}, ($urandom & 32'hFFFF_FF00) | 32'(min_len));
      apb_write({REG_MIN_TOTAL_TIME, 2'b00}, ($urandom & 32'hFFC0_0000) | 32'(min_time));
      apb_write({REG_BURST_LEVEL, 2'b00}, ($urandom & 32'hFFFF_FFFE) | 32'(mark));
      cur_mark = mark;
      settings_used++;
   endtask

   task automatic random_frame();
      int   len;
      int   r;
      logic want;
      quiet = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 10)
         len = 0;
      else if (r < 88)
         len = $urandom_range(1, 12);
      else
         len = $urandom_range(13, 60);
      if (len == 0) begin
         send_edge(1'($urandom_range(0, 1)), pick_duration(), 1'b1);
      end else begin
         // a leading space that must be ignored
         if ($urandom_range(0, 9) == 0)
            send_edge(!cur_mark, pick_duration(), 1'b0);
         want = cur_mark;
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 11) == 0) begin
               send_edge(!want, pick_duration(), k == len - 1);
            end else begin
               send_edge(want, pick_duration(), k == len - 1);
               want = !want;
            end
         end
      end
      if ($urandom_range(0, 39) == 0)
         drain_results();
   endtask

   task automatic random_phase(input int n_items);
      int target;
      target = edges_sent + n_items;
      while (edges_sent < target)
         random_frame();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset thresholds: at least 4 kept durations, the reset minimum total time, mark on low
      send_edge(cur_mark, 15'd0, 1'b1);              // empty frame
      send_edge(!cur_mark, 15'd100, 1'b0);           // space before any mark
      send_edge(cur_mark, 15'd0, 1'b0);              // zero-length mark
      send_edge(cur_mark, 15'd32767, 1'b0);
      send_edge(!cur_mark, 15'd1, 1'b0);
      send_edge(cur_mark, 15'd500, 1'b0);
      send_edge(cur_mark, 15'd600, 1'b0);            // breaks alternation
      send_edge(!cur_mark, 15'd700, 1'b0);
      send_edge(cur_mark, 15'd800, 1'b1);            // kept and accepted
      for (int k = 0; k < 4; k++)
         send_edge(k[0] ? !cur_mark : cur_mark, 15'd10, k == 3);  // total too small
      for (int k = 0; k < 4; k++)
         send_edge(k[0] ? !cur_mark : cur_mark, 15'd3000, 1'b0);
      send_edge(!cur_mark, 15'd5, 1'b1);             // dropped edge ends the frame
      send_edge(cur_mark, 15'd5000, 1'b0);
      send_edge(!cur_mark, 15'd5000, 1'b1);          // too few edges
      drain_results();

      // full store and the largest total that fits
      apb_write({RegUnused, 2'b00}, $urandom);
      set_config(8'd128, 22'd4194176, 1'b1);
      quiet = 1'b1;
      for (int k = 0; k < MaxKept + 2; k++)
         send_edge(k[0] ? !cur_mark : cur_mark, {DurWidth{1'b1}}, k == MaxKept + 1);
      quiet = 1'b0;
      for (int k = 0; k < MaxKept; k++)
         send_edge(k[0] ? !cur_mark : cur_mark, (k == 0) ? 15'd32766 : 15'd32767,
                   k == MaxKept - 1);
      drain_results();

      set_config(MIN_LENGTH_RESET, MIN_TOTAL_TIME_RESET, 1'b0);
      random_phase(50);
      drain_results();
      set_config(8'd1, 22'd0, 1'b1);
      random_phase(40);
      drain_results();
      set_config(8'd255, {TotalWidth{1'b1}}, 1'b0);
      random_phase(30);
      drain_results();
      set_config(8'd0, 22'd0, 1'b1);
      random_phase(30);
      drain_results();
      set_config(CountWidth'($urandom_range(1, 16)), TotalWidth'($urandom_range(0, 20000)),
                 1'($urandom_range(0, 1)));
      random_phase(60);
      drain_results();

      $display("Sent %0d edges in %0d frames under %0d register settings, %0d results checked",
               edges_sent, frames_sent, settings_used, check_count);
      $display("Covered empty, short and accepted frames, broken alternation and a full store");
      if (check_errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timeout with %0d results outstanding", check_pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
